@@ rtl/bc_pkg.sv @@
// bc_pkg: shared widths, state type and pascal-triangle rom for the
// binomial coefficient unit. no dependencies.
`timescale 1ns / 1ps

package bc_pkg;

    localparam int N_W       = 6;   // width of n and k
    localparam int IDX_W     = 5;   // width of the step index and reduced k (at most 31)
    localparam int COEF_W    = 59;  // width of a coefficient
    localparam int PROD_W    = 64;  // width of the intermediate product
    localparam int MUL_STEPS = N_W; // one multiplier bit per cycle
    localparam int ROM_MAX_N = 10;  // rom covers rows 0..10
    localparam int ROM_ROWS  = ROM_MAX_N + 1;
    localparam int ROM_IDX_W = $clog2(ROM_ROWS);

    localparam logic [N_W-1:0] N_TOP  = 6'd63; // top n, formed from row 62
    localparam logic [N_W-1:0] N_LOOP = 6'd62; // row used for top n

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FIN
    } bc_state_t;

    localparam logic [7:0] PASCAL_ROM [0:ROM_ROWS-1][0:ROM_ROWS-1] = '{
        '{8'd1, 8'd0,  8'd0,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,  8'd0,  8'd0},
        '{8'd1, 8'd1,  8'd0,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,  8'd0,  8'd0},
        '{8'd1, 8'd2,  8'd1,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,  8'd0,  8'd0},
        '{8'd1, 8'd3,  8'd3,  8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,  8'd0,  8'd0},
        '{8'd1, 8'd4,  8'd6,  8'd4,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,  8'd0,  8'd0},
        '{8'd1, 8'd5,  8'd10, 8'd10,  8'd5,   8'd1,   8'd0,   8'd0,   8'd0,  8'd0,  8'd0},
        '{8'd1, 8'd6,  8'd15, 8'd20,  8'd15,  8'd6,   8'd1,   8'd0,   8'd0,  8'd0,  8'd0},
        '{8'd1, 8'd7,  8'd21, 8'd35,  8'd35,  8'd21,  8'd7,   8'd1,   8'd0,  8'd0,  8'd0},
        '{8'd1, 8'd8,  8'd28, 8'd56,  8'd70,  8'd56,  8'd28,  8'd8,   8'd1,  8'd0,  8'd0},
        '{8'd1, 8'd9,  8'd36, 8'd84,  8'd126, 8'd126, 8'd84,  8'd36,  8'd9,  8'd1,  8'd0},
        '{8'd1, 8'd10, 8'd45, 8'd120, 8'd210, 8'd252, 8'd210, 8'd120, 8'd45, 8'd10, 8'd1}
    };

endpackage

@@ rtl/binomial_coefficient_unit.sv @@
// binomial_coefficient_unit: top level, step sequencer and output register.
// depends on bc_pkg, bc_mul and bc_div.
`timescale 1ns / 1ps

// Binomial coefficient unit: gives C(n,k) for a 6-bit n and k.
// Input channel s_valid/s_ready carries n and k; result channel
// m_valid/m_ready carries the 59-bit coefficient, one result beat per
// input beat. k above n gives 0; n = 63 gives C(62,k) + C(62,k-1),
// saturated to all ones in 59 bits.
// Small rows (n up to ROM_LIMIT, at most 10), k above n and k equal to
// 0 or n skip the loop: the result is set on the input beat and moves
// to the output register in ST_FIN. Other items run min(k, n-k) steps
// (min(k, 63-k) for n = 63) of acc = acc*(n+1-i)/i; each step runs the
// shift-add multiplier, then the bit-serial divider, which takes most
// of the step. At most 31 steps are run.
// One item is in work at a time; s_ready is high whenever the sequencer
// is idle, also while a finished result waits in the output register.
// If the receiver stalls, a completed item waits until the output
// register is free. Reset clears the sequencer and the output valid.

module binomial_coefficient_unit
    import bc_pkg::*;
#(
    parameter int ROM_LIMIT = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [N_W-1:0]    s_n_value,
    input  logic [N_W-1:0]    s_k_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [COEF_W-1:0] m_coefficient
);

    localparam logic [N_W-1:0] ROM_TOP =
        N_W'((ROM_LIMIT < ROM_MAX_N) ? ROM_LIMIT : ROM_MAX_N);

    bc_state_t state_reg, state_next;

    logic [N_W-1:0]    n_reg, n_next;
    logic [IDX_W-1:0]  kk_reg, kk_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic              top_reg, top_next;
    logic [COEF_W-1:0] acc_reg, acc_next;
    logic [COEF_W-1:0] res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    logic [COEF_W-1:0] m_coef_reg, m_coef_next;

    logic              in_beat;
    logic              mul_start, div_start, fin_load;
    logic              mul_done, div_done;
    logic [PROD_W-1:0] product, quotient;
    logic [N_W-1:0]    mul_factor;

    // input decode
    logic              k_over, n_top, use_rom, k_zero;
    logic [N_W-1:0]    n_rest, k_min;
    logic [COEF_W-1:0] direct_val;
    logic [COEF_W-1:0] q_val;
    logic [COEF_W:0]   top_sum;
    logic              last_step;

    assign k_over  = (s_k_value > s_n_value);
    assign n_top   = (s_n_value == N_TOP);
    assign use_rom = (s_n_value <= ROM_TOP);
    assign n_rest  = n_top ? (N_TOP - s_k_value) : (s_n_value - s_k_value);
    assign k_min   = (n_rest < s_k_value) ? n_rest : s_k_value;
    assign k_zero  = (k_min == '0);

    always_comb begin
        if (k_over) begin
            direct_val = '0;
        end else if (use_rom) begin
            direct_val = COEF_W'(PASCAL_ROM[s_n_value[ROM_IDX_W-1:0]]
                                           [s_k_value[ROM_IDX_W-1:0]]);
        end else begin
            direct_val = COEF_W'(1);
        end
    end

    assign in_beat    = s_valid && s_ready;
    assign mul_factor = n_reg - N_W'(i_reg) + N_W'(1);
    assign q_val      = quotient[COEF_W-1:0];
    assign top_sum    = {1'b0, q_val} + {1'b0, acc_reg};
    assign last_step  = (i_reg == kk_reg);

    bc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (acc_reg),
        .mplier  (mul_factor),
        .done    (mul_done),
        .product (product)
    );

    bc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (product),
        .divisor  (i_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (k_over || use_rom || k_zero) begin
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_MUL_GO;
                    end
                end
            end
            ST_MUL_GO:   state_next = ST_MUL_WAIT;
            ST_MUL_WAIT: if (mul_done) state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = last_step ? ST_FIN : ST_MUL_GO;
                end
            end
            ST_FIN: if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready   = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        fin_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:     s_ready = 1'b1;
            ST_MUL_GO:   mul_start = 1'b1;
            ST_MUL_WAIT: ;
            ST_DIV_GO:   div_start = 1'b1;
            ST_DIV_WAIT: ;
            ST_FIN:      fin_load = !m_valid_reg || m_ready;
            default:     ;
        endcase
    end

    // datapath registers
    always_comb begin
        n_next       = n_reg;
        kk_next      = kk_reg;
        i_next       = i_reg;
        top_next     = top_reg;
        acc_next     = acc_reg;
        res_next     = res_reg;
        m_coef_next  = m_coef_reg;
        m_valid_next = m_valid_reg && !m_ready;

        if (in_beat) begin
            n_next   = n_top ? N_LOOP : s_n_value;
            kk_next  = k_min[IDX_W-1:0];
            i_next   = IDX_W'(1);
            top_next = n_top;
            acc_next = COEF_W'(1);
            res_next = direct_val;
        end

        if (state_reg == ST_DIV_WAIT && div_done) begin
            if (last_step) begin
                // top row: sum of two neighbours in row 62, clipped to the field
                if (top_reg) begin
                    res_next = top_sum[COEF_W] ? '1 : top_sum[COEF_W-1:0];
                end else begin
                    res_next = q_val;
                end
            end else begin
                acc_next = q_val;
                i_next   = i_reg + 1'b1;
            end
        end

        if (fin_load) begin
            m_coef_next  = res_reg;
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        n_reg      <= n_next;
        kk_reg     <= kk_next;
        i_reg      <= i_next;
        top_reg    <= top_next;
        acc_reg    <= acc_next;
        res_reg    <= res_next;
        m_coef_reg <= m_coef_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_coefficient = m_coef_reg;

endmodule

@@ rtl/bc_mul.sv @@
// bc_mul: shift-add multiplier, one bit of the small factor per cycle.
// depends on bc_pkg.
`timescale 1ns / 1ps

module bc_mul
    import bc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [COEF_W-1:0] mcand,
    input  logic [N_W-1:0]    mplier,
    output logic              done,
    output logic [PROD_W-1:0] product
);

    localparam int CNT_W = $clog2(MUL_STEPS);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] mcand_reg, mcand_next;
    logic [N_W-1:0]    mplier_reg, mplier_next;
    logic [PROD_W-1:0] prod_reg, prod_next;

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        prod_next   = prod_reg;
        if (start) begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            mcand_next  = PROD_W'(mcand);
            mplier_next = mplier;
            prod_next   = '0;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                prod_next = prod_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[N_W-1:1]};
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MUL_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

@@ rtl/bc_div.sv @@
// bc_div: restoring divider of the 64-bit product by the small step index,
// one quotient bit per cycle. depends on bc_pkg.
`timescale 1ns / 1ps

module bc_div
    import bc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [IDX_W-1:0]  divisor,
    output logic              done,
    output logic [PROD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(PROD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] shf_reg, shf_next;
    logic [IDX_W-1:0]  rem_reg, rem_next;
    logic [IDX_W-1:0]  dvs_reg, dvs_next;
    logic [IDX_W:0]    trial;
    logic [IDX_W:0]    diff;
    logic              q_bit;

    // partial remainder stays below the divisor, so one extra bit is enough
    assign trial = {rem_reg, shf_reg[PROD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign q_bit = (trial >= {1'b0, dvs_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        shf_next  = shf_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            shf_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = q_bit ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
            shf_next = {shf_reg[PROD_W-2:0], q_bit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(PROD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        shf_reg <= shf_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = shf_reg;

endmodule

@@ tb/tb_binomial_coefficient_unit.sv @@
// tb_binomial_coefficient_unit: self-checking bench for the binomial coefficient unit,
// with a queue-based scoreboard and directed plus random n/k beats.
// depends on bc_pkg and binomial_coefficient_unit.
`timescale 1ns / 1ps

module tb_binomial_coefficient_unit
    import bc_pkg::*;
();

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int RANDOM_ITEMS = 266;
    localparam int DIRECTED_CNT = 24;
    localparam int HOLD_CYCLES  = 6000;
    localparam bit [63:0] COEF_ALL = (64'd1 << COEF_W) - 64'd1;

    class coef_board;
        bit [COEF_W-1:0] want_q[$];
        bit [N_W-1:0]    n_q[$];
        bit [N_W-1:0]    k_q[$];
        int              fail_count;

        // multiplicative row walk, exact for n up to 62
        function bit [63:0] row_coef(bit [63:0] n, bit [63:0] k);
            bit [63:0] acc;
            bit [63:0] kk;
            bit [63:0] j;
            if (k > n)
                return 64'd0;
            kk = (n - k < k) ? n - k : k;
            acc = 64'd1;
            for (j = 64'd1; j <= kk; j++)
                acc = ((n - kk + j) * acc) / j;
            return acc;
        endfunction

        function bit [COEF_W-1:0] binomial(bit [N_W-1:0] n, bit [N_W-1:0] k);
            bit [63:0] sum;
            if (k > n) begin
                sum = 64'd0;
            end else if (n == N_TOP) begin
                // top row built from row 62, clipped to the field width
                sum = row_coef(64'(N_LOOP), 64'(k));
                if (k != '0)
                    sum = sum + row_coef(64'(N_LOOP), 64'(k) - 64'd1);
                if (sum > COEF_ALL)
                    sum = COEF_ALL;
            end else begin
                sum = row_coef(64'(n), 64'(k));
            end
            return sum[COEF_W-1:0];
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            fail_count++;
        endtask

        function void note_beat(bit [N_W-1:0] n, bit [N_W-1:0] k);
            want_q.push_back(binomial(n, k));
            n_q.push_back(n);
            k_q.push_back(k);
        endfunction

        task check_beat(bit [COEF_W-1:0] got);
            bit [COEF_W-1:0] want;
            bit [N_W-1:0]    n;
            bit [N_W-1:0]    k;
            if (want_q.size() == 0) begin
                report($sformatf("unexpected result beat %0d", got));
                return;
            end
            want = want_q.pop_front();
            n = n_q.pop_front();
            k = k_q.pop_front();
            if (got !== want)
                report($sformatf("C(%0d,%0d) got %0d want %0d", n, k, got, want));
        endtask

        function int pending();
            return want_q.size();
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [N_W-1:0]    s_n_value;
    logic [N_W-1:0]    s_k_value;
    logic              m_valid;
    logic              m_ready;
    logic [COEF_W-1:0] m_coefficient;

    coef_board sb;
    bit        hold_active = 1'b0;
    int        cycle_count = 0;

    bit [N_W-1:0] directed_n [0:DIRECTED_CNT-1] = '{
        6'd0, 6'd0, 6'd1, 6'd10, 6'd10, 6'd10, 6'd10, 6'd11, 6'd11, 6'd11, 6'd62, 6'd62,
        6'd62, 6'd62, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd40, 6'd21
    };
    bit [N_W-1:0] directed_k [0:DIRECTED_CNT-1] = '{
        6'd0, 6'd63, 6'd1, 6'd0, 6'd5, 6'd10, 6'd11, 6'd0, 6'd5, 6'd12, 6'd0, 6'd31,
        6'd62, 6'd63, 6'd0, 6'd1, 6'd27, 6'd28, 6'd31, 6'd32, 6'd62, 6'd63, 6'd20, 6'd42
    };

    binomial_coefficient_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_n_value     (s_n_value),
        .s_k_value     (s_k_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_coefficient (m_coefficient)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_binomial_coefficient_unit NOT OK");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_beat(s_n_value, s_k_value);
            if (m_valid && m_ready)
                sb.check_beat(m_coefficient);
        end
    end

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 18));
    endfunction

    // rom rows with k up to 11, rows 11..63 with in-range k, and some fully random n and k
    function automatic void pick_item(output bit [N_W-1:0] n, output bit [N_W-1:0] k);
        int sel;
        sel = int'($urandom_range(0, 9));
        if (sel < 4) begin
            n = N_W'($urandom_range(0, 10));
            k = N_W'($urandom_range(0, 11));
        end else if (sel < 8) begin
            n = N_W'($urandom_range(11, 63));
            k = N_W'($urandom_range(0, n));
        end else begin
            n = N_W'($urandom);
            k = N_W'($urandom);
        end
    endfunction

    task automatic send_item(bit [N_W-1:0] n, bit [N_W-1:0] k, int gap);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_n_value <= n;
        s_k_value <= k;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // result side: random stalls, one long hold-off to back the block up
    initial begin
        int stall;
        int got;
        got = 0;
        wait (aresetn === 1'b1);
        forever begin
            if (got == 50) begin
                hold_active = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_active = 1'b0;
            end else begin
                stall = draw_gap(got >= 150 && got < 190);
                if (stall != 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            got++;
        end
    end

    initial begin
        bit [N_W-1:0] n;
        bit [N_W-1:0] k;
        sb = new();
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_n_value <= '0;
        s_k_value <= '0;
        m_ready   <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_CNT; i++)
            send_item(directed_n[i], directed_k[i], draw_gap(1'b0));

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pick_item(n, k);
            send_item(n, k, draw_gap(hold_active || (i >= 100 && i < 140)));
        end
        s_valid <= 1'b0;

        // let the last input beat reach the scoreboard first
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("tb_binomial_coefficient_unit OK");
        else
            $display("tb_binomial_coefficient_unit NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/bc_pkg.sv
rtl/bc_mul.sv
rtl/bc_div.sv
rtl/binomial_coefficient_unit.sv
tb/tb_binomial_coefficient_unit.sv
